@@ design/magic_header_frame_deframer_macros.svh @@
// ----------------------------------------------------------------------------
// deframer assertion macros
// shared concurrent assertion forms for the frame deframer
// ----------------------------------------------------------------------------
`ifndef MAGIC_HEADER_FRAME_DEFRAMER_MACROS_SVH
`define MAGIC_HEADER_FRAME_DEFRAMER_MACROS_SVH

// same-cycle implication
`define MHFD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MHFD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/mhfd_pkg.sv @@
// ----------------------------------------------------------------------------
// deframer package
// types and constants shared by the frame deframer
// ----------------------------------------------------------------------------
package mhfd_pkg;

   localparam int HDR_LEN = 24;
   localparam logic [31:0] FRAME_LIMIT_RESET = 32'd40000;

   localparam logic [7:0] MAGIC_0 = 8'h4E;
   localparam logic [7:0] MAGIC_1 = 8'h56;
   localparam logic [7:0] MAGIC_2 = 8'h48;
   localparam logic [7:0] MAGIC_3 = 8'h31;

   typedef enum logic [1:0] {
      EV_HEADER    = 2'd0,
      EV_PAYLOAD   = 2'd1,
      EV_BAD_MAGIC = 2'd2,
      EV_TOO_BIG   = 2'd3
   } event_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
   } req_item_type;

   typedef struct packed {
      event_type   event_res;
      logic [15:0] command;
      logic [31:0] request_id;
      logic [31:0] cbor_length;
      logic [31:0] raw_length;
      logic [7:0]  payload_byte;
      logic        section;
      logic        last;
   } rsp_item_type;

endpackage

@@ design/mhfd_if.sv @@
// ----------------------------------------------------------------------------
// deframer channels
// request, response and register write channels
// ----------------------------------------------------------------------------
interface mhfd_req_if import mhfd_pkg::*; ();
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] data_byte;

   modport source (output valid, output kind, output data_byte, input ready);
   modport sink (input valid, input kind, input data_byte, output ready);
endinterface

interface mhfd_rsp_if import mhfd_pkg::*; ();
   logic        valid;
   logic        ready;
   event_type   event_res;
   logic [15:0] command;
   logic [31:0] request_id;
   logic [31:0] cbor_length;
   logic [31:0] raw_length;
   logic [7:0]  payload_byte;
   logic        section;
   logic        last;

   modport source (output valid, output event_res, output command, output request_id,
                   output cbor_length, output raw_length, output payload_byte,
                   output section, output last, input ready);
   modport sink (input valid, input event_res, input command, input request_id,
                 input cbor_length, input raw_length, input payload_byte,
                 input section, input last, output ready);
endinterface

interface mhfd_csr_if import mhfd_pkg::*; ();
   logic        valid;
   logic        ready;
   logic [31:0] max_frame_bytes;

   modport source (output valid, output max_frame_bytes, input ready);
   modport sink (input valid, input max_frame_bytes, output ready);
endinterface

@@ design/mhfd_in_stage.sv @@
// ----------------------------------------------------------------------------
// deframer input stage
// registers one request and holds it until the parser takes it
// ----------------------------------------------------------------------------
module mhfd_in_stage import mhfd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  req_item_type in_item,
   input  logic         advance,
   output logic         item_valid,
   output req_item_type item
);

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;

   assign in_ready   = !valid_ff || advance;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (in_valid && in_ready) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

endmodule

@@ design/mhfd_parser.sv @@
// ----------------------------------------------------------------------------
// deframer parser
// header gathering, magic and size checks, payload tagging
// ----------------------------------------------------------------------------
`include "magic_header_frame_deframer_macros.svh"

module mhfd_parser import mhfd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         fire,
   input  req_item_type item,
   input  logic [31:0]  max_frame_bytes,
   output logic         res_valid,
   output rsp_item_type res
);

   logic [4:0]  hdr_count_ff;
   logic [4:0]  hdr_count_in;
   logic [7:0]  hdr_ff [0:HDR_LEN-2];
   logic        in_payload_ff;
   logic        in_payload_in;
   logic [31:0] cbor_rem_ff;
   logic [31:0] cbor_rem_in;
   logic [31:0] raw_rem_ff;
   logic [31:0] raw_rem_in;
   logic        hdr_shift;

   logic [15:0] cmd;
   logic [31:0] rid;
   logic [31:0] clen;
   logic [31:0] rlen;
   logic [33:0] total;
   logic        magic_ok;
   logic        too_big;
   logic        hdr_done;

   assign cmd  = {hdr_ff[6], hdr_ff[7]};
   assign rid  = {hdr_ff[10], hdr_ff[11], hdr_ff[12], hdr_ff[13]};
   assign clen = {hdr_ff[14], hdr_ff[15], hdr_ff[16], hdr_ff[17]};
   assign rlen = {hdr_ff[18], hdr_ff[19], hdr_ff[20], hdr_ff[21]};
   assign total = 34'(HDR_LEN) + {2'b00, clen} + {2'b00, rlen};
   assign magic_ok = (hdr_ff[0] == MAGIC_0) && (hdr_ff[1] == MAGIC_1) &&
                     (hdr_ff[2] == MAGIC_2) && (hdr_ff[3] == MAGIC_3);
   assign too_big  = total > {2'b00, max_frame_bytes};
   assign hdr_done = hdr_count_ff == 5'(HDR_LEN - 1);

   always_comb begin
      hdr_count_in  = hdr_count_ff;
      in_payload_in = in_payload_ff;
      cbor_rem_in   = cbor_rem_ff;
      raw_rem_in    = raw_rem_ff;
      hdr_shift     = 1'b0;
      res_valid     = 1'b0;
      res           = '0;
      if (item.kind) begin
         hdr_count_in  = '0;
         in_payload_in = 1'b0;
         cbor_rem_in   = '0;
         raw_rem_in    = '0;
      end else if (in_payload_ff) begin
         res_valid        = 1'b1;
         res.event_res    = EV_PAYLOAD;
         res.payload_byte = item.data_byte;
         if (cbor_rem_ff != '0) begin
            cbor_rem_in = cbor_rem_ff - 32'd1;
            res.section = 1'b0;
         end else begin
            if (raw_rem_ff != '0) begin
               raw_rem_in = raw_rem_ff - 32'd1;
            end
            res.section = 1'b1;
         end
         if (cbor_rem_in == '0 && raw_rem_in == '0) begin
            res.last      = 1'b1;
            in_payload_in = 1'b0;
         end
      end else begin
         hdr_shift = 1'b1;
         if (!hdr_done) begin
            hdr_count_in = hdr_count_ff + 5'd1;
         end else begin
            hdr_count_in    = '0;
            res_valid       = 1'b1;
            res.command     = cmd;
            res.request_id  = rid;
            res.cbor_length = clen;
            res.raw_length  = rlen;
            if (!magic_ok) begin
               res.event_res = EV_BAD_MAGIC;
            end else if (too_big) begin
               res.event_res = EV_TOO_BIG;
            end else begin
               res.event_res = EV_HEADER;
               cbor_rem_in   = clen;
               raw_rem_in    = rlen;
               if (clen == '0 && rlen == '0) begin
                  res.last = 1'b1;
               end else begin
                  in_payload_in = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_count_ff  <= '0;
         in_payload_ff <= 1'b0;
         cbor_rem_ff   <= '0;
         raw_rem_ff    <= '0;
      end else if (fire) begin
         hdr_count_ff  <= hdr_count_in;
         in_payload_ff <= in_payload_in;
         cbor_rem_ff   <= cbor_rem_in;
         raw_rem_ff    <= raw_rem_in;
      end
   end

   // header bytes 0 to 22 line up with their index once 23 are in
   always_ff @(posedge clock) begin
      if (fire && hdr_shift) begin
         for (int i = 0; i < HDR_LEN - 2; i++) begin
            hdr_ff[i] <= hdr_ff[i+1];
         end
         hdr_ff[HDR_LEN-2] <= item.data_byte;
      end
   end

   `MHFD_ASSERT_NOW(a_payload_event, clock, reset, fire && !item.kind && in_payload_ff, res_valid && res.event_res == EV_PAYLOAD, "payload byte without payload event")
   `MHFD_ASSERT_NEXT(a_header_opens_payload, clock, reset, fire && res_valid && res.event_res == EV_HEADER && !res.last, in_payload_ff, "accepted header did not open payload")
   `MHFD_ASSERT_NEXT(a_restart_clears, clock, reset, fire && item.kind, hdr_count_ff == '0 && !in_payload_ff, "restart left parse state")
   `MHFD_ASSERT_NOW(a_payload_remaining, clock, reset, in_payload_ff, cbor_rem_ff != '0 || raw_rem_ff != '0, "payload open with nothing left")

endmodule

@@ design/mhfd_out_stage.sv @@
// ----------------------------------------------------------------------------
// deframer result stage
// response register toward the downstream sink
// ----------------------------------------------------------------------------
module mhfd_out_stage import mhfd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         res_valid,
   input  rsp_item_type res,
   output logic         advance,
   output logic         out_valid,
   input  logic         out_ready,
   output rsp_item_type out_item
);

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type item_ff;

   assign advance   = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (advance) begin
         valid_in = res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && res_valid) begin
         item_ff <= res;
      end
   end

endmodule

@@ design/magic_header_frame_deframer.sv @@
// ----------------------------------------------------------------------------
// magic header frame deframer
// byte stream deframer with magic and size checks
// ----------------------------------------------------------------------------
// Takes one request per clock cycle through the input register, then the parse
// logic into the response register; the rate is set by the response register,
// which frees up in any cycle the sink takes its response. Header bytes give no
// response until the 24th, which gives a header, bad magic or too big event;
// each payload byte gives one payload event. The frame limit register is to
// be written only while the block is idle; the block does not enforce this.
module magic_header_frame_deframer import mhfd_pkg::*; (
   input logic        clock,
   input logic        reset,
   mhfd_req_if.sink   req_port,
   mhfd_rsp_if.source rsp_port,
   mhfd_csr_if.sink   csr_port
);

   logic [31:0]  max_frame_ff;
   logic         advance;
   logic         item_valid;
   req_item_type in_item;
   req_item_type item;
   logic         res_valid;
   rsp_item_type res;
   rsp_item_type out_item;

   assign csr_port.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_frame_ff <= FRAME_LIMIT_RESET;
      end else if (csr_port.valid) begin
         max_frame_ff <= csr_port.max_frame_bytes;
      end
   end

   assign in_item.kind      = req_port.kind;
   assign in_item.data_byte = req_port.data_byte;

   mhfd_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_port.valid),
      .in_ready   (req_port.ready),
      .in_item    (in_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   mhfd_parser u_parser (
      .clock           (clock),
      .reset           (reset),
      .fire            (item_valid && advance),
      .item            (item),
      .max_frame_bytes (max_frame_ff),
      .res_valid       (res_valid),
      .res             (res)
   );

   mhfd_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .res_valid (item_valid && res_valid),
      .res       (res),
      .advance   (advance),
      .out_valid (rsp_port.valid),
      .out_ready (rsp_port.ready),
      .out_item  (out_item)
   );

   assign rsp_port.event_res    = out_item.event_res;
   assign rsp_port.command      = out_item.command;
   assign rsp_port.request_id   = out_item.request_id;
   assign rsp_port.cbor_length  = out_item.cbor_length;
   assign rsp_port.raw_length   = out_item.raw_length;
   assign rsp_port.payload_byte = out_item.payload_byte;
   assign rsp_port.section      = out_item.section;
   assign rsp_port.last         = out_item.last;

endmodule
